// ===== rtl/scan_pattern_angle_generator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Scan pattern angle generator: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef SCAN_PATTERN_ANGLE_GENERATOR_TOP_DEFINES_SVH
`define SCAN_PATTERN_ANGLE_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication
`define SPAG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spag: same-cycle check failed");

// Next-cycle implication
`define SPAG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spag: next-cycle check failed");

`endif

// ===== rtl/spag_pkg.sv =====
// ----------------------------------------------------------------------------
// spag_pkg
// Widths, codes, rotation constants and shared types of the scan pattern
// angle generator.
// ----------------------------------------------------------------------------
package spag_pkg;

    // Field and datapath widths
    localparam int TIME_W         = 48;
    localparam int TIME_FRAC_BITS = 32;
    localparam int FREQ_W         = 32;
    localparam int PHASE_FB       = 16 + TIME_FRAC_BITS;
    localparam int PROD_W         = TIME_W + FREQ_W;
    localparam int TURN_W         = 32;
    localparam int NUM_W          = PROD_W - PHASE_FB + TURN_W;
    localparam int FOV_W          = 27;
    localparam int ANGLE_W        = 27;
    localparam int LINES_W        = 16;
    localparam int MODE_W         = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int ROT_W          = 32;
    localparam int Z_W            = 34;
    localparam int RADIUS_W       = 26;
    localparam int MAX_STEPS      = 32;
    localparam int SINE_STEPS_DEFAULT = 24;

    // Pattern modes
    localparam logic [MODE_W-1:0] MODE_RASTER    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SINUSOID  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LISSAJOUS = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SPIRAL    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ROSETTE   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CIRCULAR  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BLANK_LO  = 3'd6;
    localparam logic [MODE_W-1:0] MODE_BLANK_HI  = 3'd7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOV_HORIZONTAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOV_VERTICAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_FREQUENCY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_FREQUENCY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RASTER_LINES   = 3'd5;

    // Turn constants (Q0.32 turns) and rotation gain (Q2.30)
    localparam logic signed [Z_W-1:0]   TURN_HALF    = 34'sd2147483648;
    localparam logic signed [Z_W-1:0]   TURN_QUARTER = 34'sd1073741824;
    localparam logic [TURN_W-1:0]       TURN_EIGHTH  = 32'h2000_0000;
    localparam logic signed [ROT_W-1:0] ROT_GAIN     = 32'sd652032874;
    localparam logic [LINES_W-1:0]      SPIRAL_TURNS = 16'd5;

    // arctan(2^-i) in Q0.32 turns
    localparam logic [TURN_W-1:0] ATAN_TURNS [0:MAX_STEPS-1] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Phase pair handed along the divider cells
    typedef struct packed {
        logic [TURN_W-1:0] fx;
        logic [TURN_W-1:0] fy;
    } t_phase_pair;

    // Values handed along the rotation cells
    typedef struct packed {
        logic [TURN_W-1:0]   fx;
        logic [TURN_W-1:0]   quo;
        logic [RADIUS_W-1:0] radius;
        logic                flip_x;
        logic                flip_y;
    } t_rot_side;

    // One rotator's working vector
    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [Z_W-1:0]   z;
    } t_rot_state;

    // Folded phase and half-turn flag
    typedef struct packed {
        logic signed [Z_W-1:0] z;
        logic                  flip;
    } t_fold;

    // Fold a turn fraction into the right half plane
    function automatic t_fold fold_phase(input logic [TURN_W-1:0] p);
        t_fold f;
        f.z    = Z_W'($signed(p));
        f.flip = 1'b0;
        if (f.z > TURN_QUARTER) begin
            f.z    = f.z - TURN_HALF;
            f.flip = 1'b1;
        end else if (f.z < -TURN_QUARTER) begin
            f.z    = f.z + TURN_HALF;
            f.flip = 1'b1;
        end
        return f;
    endfunction

endpackage

// ===== rtl/spag_ifs.sv =====
// ----------------------------------------------------------------------------
// spag channel interfaces
// Valid/ready channels for time stamps, angle pairs and register writes.
// ----------------------------------------------------------------------------
interface spag_time_if;
    logic                            valid;
    logic                            ready;
    logic [spag_pkg::TIME_W-1:0]     time_stamp;
    modport source (output valid, output time_stamp, input ready);
    modport sink   (input valid, input time_stamp, output ready);
endinterface

interface spag_angle_if;
    logic                             valid;
    logic                             ready;
    logic signed [spag_pkg::ANGLE_W-1:0] azimuth_angle;
    logic signed [spag_pkg::ANGLE_W-1:0] elevation_angle;
    modport source (output valid, output azimuth_angle, output elevation_angle, input ready);
    modport sink   (input valid, input azimuth_angle, input elevation_angle, output ready);
endinterface

interface spag_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [spag_pkg::CFG_IDX_W-1:0]    index;
    logic [spag_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/spag_div_cell.sv =====
// ----------------------------------------------------------------------------
// spag_div_cell
// One restoring division step: shift in a numerator bit, subtract the
// divisor when it fits, and append the quotient bit.
// ----------------------------------------------------------------------------
module spag_div_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [spag_pkg::LINES_W-1:0]      i_divisor,
    input  logic                              i_valid,
    input  logic [spag_pkg::LINES_W-1:0]      i_rem,
    input  logic [spag_pkg::NUM_W-1:0]        i_num,
    input  logic [spag_pkg::TURN_W-1:0]       i_quo,
    input  spag_pkg::t_phase_pair             i_side,
    output logic                              o_valid,
    output logic [spag_pkg::LINES_W-1:0]      o_rem,
    output logic [spag_pkg::NUM_W-1:0]        o_num,
    output logic [spag_pkg::TURN_W-1:0]       o_quo,
    output spag_pkg::t_phase_pair             o_side
);

    logic                             r_valid;
    logic [spag_pkg::LINES_W-1:0]     r_rem;
    logic [spag_pkg::NUM_W-1:0]       r_num;
    logic [spag_pkg::TURN_W-1:0]      r_quo;
    spag_pkg::t_phase_pair            r_side;

    logic [spag_pkg::LINES_W:0]       w_trial;
    logic                             w_fits;
    logic [spag_pkg::LINES_W-1:0]     n_rem;

    // Trial subtract
    always_comb begin
        w_trial = {i_rem, i_num[spag_pkg::NUM_W-1]};
        w_fits  = (w_trial >= {1'b0, i_divisor});
        if (w_fits) begin
            n_rem = spag_pkg::LINES_W'(w_trial - {1'b0, i_divisor});
        end else begin
            n_rem = w_trial[spag_pkg::LINES_W-1:0];
        end
    end

    // Advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_num  <= {i_num[spag_pkg::NUM_W-2:0], 1'b0};
            r_quo  <= {i_quo[spag_pkg::TURN_W-2:0], w_fits};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

// ===== rtl/spag_rot_cell.sv =====
// ----------------------------------------------------------------------------
// spag_rot_cell
// One fixed rotation step applied to two vectors at once: rotate toward
// the residual angle by arctan(2^-STEP).
// ----------------------------------------------------------------------------
module spag_rot_cell #(
    parameter int STEP = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  spag_pkg::t_rot_state    i_rot_x,
    input  spag_pkg::t_rot_state    i_rot_y,
    input  spag_pkg::t_rot_side     i_side,
    output logic                    o_valid,
    output spag_pkg::t_rot_state    o_rot_x,
    output spag_pkg::t_rot_state    o_rot_y,
    output spag_pkg::t_rot_side     o_side
);

    localparam logic signed [spag_pkg::Z_W-1:0] ANGLE =
        $signed({2'b00, spag_pkg::ATAN_TURNS[STEP]});

    logic                  r_valid;
    spag_pkg::t_rot_state  r_rot_x;
    spag_pkg::t_rot_state  r_rot_y;
    spag_pkg::t_rot_side   r_side;

    spag_pkg::t_rot_state  n_rot_x;
    spag_pkg::t_rot_state  n_rot_y;

    // Rotate one vector by one step
    function automatic spag_pkg::t_rot_state rot_step(input spag_pkg::t_rot_state s);
        spag_pkg::t_rot_state  r;
        logic signed [spag_pkg::ROT_W-1:0] dx;
        logic signed [spag_pkg::ROT_W-1:0] dy;
        dx = s.y >>> STEP;
        dy = s.x >>> STEP;
        if (!s.z[spag_pkg::Z_W-1]) begin
            r.x = s.x - dx;
            r.y = s.y + dy;
            r.z = s.z - ANGLE;
        end else begin
            r.x = s.x + dx;
            r.y = s.y - dy;
            r.z = s.z + ANGLE;
        end
        return r;
    endfunction

    always_comb begin
        n_rot_x = rot_step(i_rot_x);
        n_rot_y = rot_step(i_rot_y);
    end

    // Advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot_x <= n_rot_x;
            r_rot_y <= n_rot_y;
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rot_x = r_rot_x;
    assign o_rot_y = r_rot_y;
    assign o_side  = r_side;

endmodule

// ===== rtl/scan_pattern_angle_generator_top.sv =====
// ----------------------------------------------------------------------------
// scan_pattern_angle_generator_top
// Time stamp in, azimuth/elevation pair out, for the selected scan pattern.
// ----------------------------------------------------------------------------
// The block takes one time stamp per clock while the output is not held
// and returns one angle pair per time stamp, in order. The pipeline runs
// through the row of one-bit division cells that reduces the whole cycles
// modulo the line count or the spiral turn count, followed by the row of
// rotation cells that forms sine and cosine, with a 64-bit phase numerator
// and, by default, 24 sine steps. When the result at the output is not
// taken, the whole pipeline holds. Register writes are taken in every cycle
// and must only be made while no time stamp is in flight.
`include "scan_pattern_angle_generator_top_defines.svh"

module scan_pattern_angle_generator_top #(
    parameter int SINE_STEPS = spag_pkg::SINE_STEPS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spag_time_if.sink            i_time,
    spag_angle_if.source         o_angle,
    spag_cfg_if.sink             i_cfg
);

    localparam int NUM_W   = spag_pkg::NUM_W;
    localparam int TURN_W  = spag_pkg::TURN_W;
    localparam int PROD_W  = spag_pkg::PROD_W;
    localparam int FOV_W   = spag_pkg::FOV_W;
    localparam int ROT_W   = spag_pkg::ROT_W;
    localparam int Z_W     = spag_pkg::Z_W;
    localparam int A_W     = FOV_W + 1;
    localparam int B_W     = Z_W;
    localparam int P_W     = A_W + B_W;
    localparam int MP_W    = FOV_W + TURN_W;

    localparam logic [1:0] SH_30 = 2'd0;
    localparam logic [1:0] SH_31 = 2'd1;
    localparam logic [1:0] SH_32 = 2'd2;

    localparam logic signed [P_W-1:0] SAT_MAX = P_W'(67108863);
    localparam logic signed [P_W-1:0] SAT_MIN = -P_W'(67108864);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [spag_pkg::MODE_W-1:0]  r_mode;
    logic [FOV_W-1:0]             r_fov_h;
    logic [FOV_W-1:0]             r_fov_v;
    logic [spag_pkg::FREQ_W-1:0]  r_fast_freq;
    logic [spag_pkg::FREQ_W-1:0]  r_slow_freq;
    logic [spag_pkg::LINES_W-1:0] r_lines;

    assign i_cfg.ready = 1'b1;

    // Write the addressed register, drop writes past the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= spag_pkg::MODE_RASTER;
            r_fov_h     <= '0;
            r_fov_v     <= '0;
            r_fast_freq <= '0;
            r_slow_freq <= '0;
            r_lines     <= spag_pkg::LINES_W'(1);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                spag_pkg::CFG_PATTERN_MODE:   r_mode      <= i_cfg.data[spag_pkg::MODE_W-1:0];
                spag_pkg::CFG_FOV_HORIZONTAL: r_fov_h     <= i_cfg.data[FOV_W-1:0];
                spag_pkg::CFG_FOV_VERTICAL:   r_fov_v     <= i_cfg.data[FOV_W-1:0];
                spag_pkg::CFG_FAST_FREQUENCY: r_fast_freq <= i_cfg.data;
                spag_pkg::CFG_SLOW_FREQUENCY: r_slow_freq <= i_cfg.data;
                spag_pkg::CFG_RASTER_LINES:   r_lines     <= i_cfg.data[spag_pkg::LINES_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable: hold everything while the output waits
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic w_en;

    assign w_en         = !r_out_valid || o_angle.ready;
    assign i_time.ready = w_en;

    // ------------------------------------------------------------------
    // Stage 1: partial products of frequency times time
    // ------------------------------------------------------------------
    logic                r_m1_valid;
    logic [63:0]         r_pp_fast_lo;
    logic [47:0]         r_pp_fast_hi;
    logic [63:0]         r_pp_slow_lo;
    logic [47:0]         r_pp_slow_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (w_en) begin
            r_m1_valid <= i_time.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pp_fast_lo <= r_fast_freq * i_time.time_stamp[31:0];
            r_pp_fast_hi <= r_fast_freq * i_time.time_stamp[47:32];
            r_pp_slow_lo <= r_slow_freq * i_time.time_stamp[31:0];
            r_pp_slow_hi <= r_slow_freq * i_time.time_stamp[47:32];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sum partials into cycles, pick phases
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]   w_fast_prod;
    logic [PROD_W-1:0]   w_slow_prod;
    logic [TURN_W-1:0]   w_fy_raw;
    logic                r_m2_valid;
    logic [NUM_W-1:0]    r_num;
    spag_pkg::t_phase_pair r_phase;

    assign w_fast_prod = PROD_W'(r_pp_fast_lo) + {r_pp_fast_hi, 32'd0};
    assign w_slow_prod = PROD_W'(r_pp_slow_lo) + {r_pp_slow_hi, 32'd0};
    assign w_fy_raw    = w_slow_prod[spag_pkg::PHASE_FB-1 -: TURN_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (w_en) begin
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num      <= w_fast_prod[PROD_W-1 -: NUM_W];
            r_phase.fx <= w_fast_prod[spag_pkg::PHASE_FB-1 -: TURN_W];
            r_phase.fy <= (r_mode == spag_pkg::MODE_LISSAJOUS) ?
                          w_fy_raw + spag_pkg::TURN_EIGHTH : w_fy_raw;
        end
    end

    // ------------------------------------------------------------------
    // Division cells: quotient low bits and remainder over the divisor
    // ------------------------------------------------------------------
    logic [spag_pkg::LINES_W-1:0] w_divisor;

    always_comb begin
        if (r_mode == spag_pkg::MODE_SPIRAL) begin
            w_divisor = spag_pkg::SPIRAL_TURNS;
        end else if (r_lines == '0) begin
            w_divisor = spag_pkg::LINES_W'(1);
        end else begin
            w_divisor = r_lines;
        end
    end

    logic                         w_dv_valid [0:NUM_W];
    logic [spag_pkg::LINES_W-1:0] w_dv_rem   [0:NUM_W];
    logic [NUM_W-1:0]             w_dv_num   [0:NUM_W];
    logic [TURN_W-1:0]            w_dv_quo   [0:NUM_W];
    spag_pkg::t_phase_pair        w_dv_side  [0:NUM_W];

    assign w_dv_valid[0] = r_m2_valid;
    assign w_dv_rem[0]   = '0;
    assign w_dv_num[0]   = r_num;
    assign w_dv_quo[0]   = '0;
    assign w_dv_side[0]  = r_phase;

    for (genvar g = 0; g < NUM_W; g++) begin : g_div
        spag_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_divisor (w_divisor),
            .i_valid   (w_dv_valid[g]),
            .i_rem     (w_dv_rem[g]),
            .i_num     (w_dv_num[g]),
            .i_quo     (w_dv_quo[g]),
            .i_side    (w_dv_side[g]),
            .o_valid   (w_dv_valid[g+1]),
            .o_rem     (w_dv_rem[g+1]),
            .o_num     (w_dv_num[g+1]),
            .o_quo     (w_dv_quo[g+1]),
            .o_side    (w_dv_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Prep stage: fold phases, spiral radius product
    // ------------------------------------------------------------------
    spag_pkg::t_fold     w_fold_x;
    spag_pkg::t_fold     w_fold_y;
    logic [FOV_W-1:0]    w_fov_min;
    logic                r_prep_valid;
    spag_pkg::t_fold     r_fold_x;
    spag_pkg::t_fold     r_fold_y;
    logic [TURN_W-1:0]   r_prep_fx;
    logic [TURN_W-1:0]   r_prep_quo;
    logic [MP_W-1:0]     r_prep_mp;

    assign w_fold_x  = spag_pkg::fold_phase(w_dv_side[NUM_W].fx);
    assign w_fold_y  = spag_pkg::fold_phase(w_dv_side[NUM_W].fy);
    assign w_fov_min = (r_fov_h < r_fov_v) ? r_fov_h : r_fov_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_valid <= 1'b0;
        end else if (w_en) begin
            r_prep_valid <= w_dv_valid[NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fold_x   <= w_fold_x;
            r_fold_y   <= w_fold_y;
            r_prep_fx  <= w_dv_side[NUM_W].fx;
            r_prep_quo <= w_dv_quo[NUM_W];
            r_prep_mp  <= w_fov_min * w_dv_quo[NUM_W];
        end
    end

    // ------------------------------------------------------------------
    // Rotation cells: cosine and sine of both phases
    // ------------------------------------------------------------------
    logic                  w_rt_valid [0:SINE_STEPS];
    spag_pkg::t_rot_state  w_rt_x     [0:SINE_STEPS];
    spag_pkg::t_rot_state  w_rt_y     [0:SINE_STEPS];
    spag_pkg::t_rot_side   w_rt_side  [0:SINE_STEPS];

    assign w_rt_valid[0]       = r_prep_valid;
    assign w_rt_x[0].x         = spag_pkg::ROT_GAIN;
    assign w_rt_x[0].y         = '0;
    assign w_rt_x[0].z         = r_fold_x.z;
    assign w_rt_y[0].x         = spag_pkg::ROT_GAIN;
    assign w_rt_y[0].y         = '0;
    assign w_rt_y[0].z         = r_fold_y.z;
    assign w_rt_side[0].fx     = r_prep_fx;
    assign w_rt_side[0].quo    = r_prep_quo;
    assign w_rt_side[0].radius = r_prep_mp[MP_W-1 -: spag_pkg::RADIUS_W];
    assign w_rt_side[0].flip_x = r_fold_x.flip;
    assign w_rt_side[0].flip_y = r_fold_y.flip;

    for (genvar g = 0; g < SINE_STEPS; g++) begin : g_rot
        spag_rot_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_rt_valid[g]),
            .i_rot_x (w_rt_x[g]),
            .i_rot_y (w_rt_y[g]),
            .i_side  (w_rt_side[g]),
            .o_valid (w_rt_valid[g+1]),
            .o_rot_x (w_rt_x[g+1]),
            .o_rot_y (w_rt_y[g+1]),
            .o_side  (w_rt_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Post stage: undo the half-turn fold
    // ------------------------------------------------------------------
    logic                     r_post_valid;
    logic signed [ROT_W-1:0]  r_cx;
    logic signed [ROT_W-1:0]  r_sx;
    logic signed [ROT_W-1:0]  r_cy;
    logic signed [ROT_W-1:0]  r_sy;
    spag_pkg::t_rot_side      r_post_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_post_valid <= 1'b0;
        end else if (w_en) begin
            r_post_valid <= w_rt_valid[SINE_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cx <= w_rt_side[SINE_STEPS].flip_x ? -w_rt_x[SINE_STEPS].x : w_rt_x[SINE_STEPS].x;
            r_sx <= w_rt_side[SINE_STEPS].flip_x ? -w_rt_x[SINE_STEPS].y : w_rt_x[SINE_STEPS].y;
            r_cy <= w_rt_side[SINE_STEPS].flip_y ? -w_rt_y[SINE_STEPS].x : w_rt_y[SINE_STEPS].x;
            r_sy <= w_rt_side[SINE_STEPS].flip_y ? -w_rt_y[SINE_STEPS].y : w_rt_y[SINE_STEPS].y;
            r_post_side <= w_rt_side[SINE_STEPS];
        end
    end

    // ------------------------------------------------------------------
    // Multiply stage: select operands per pattern, form products
    // ------------------------------------------------------------------
    logic signed [A_W-1:0] w_a_az;
    logic signed [A_W-1:0] w_a_el;
    logic signed [B_W-1:0] w_b_az;
    logic signed [B_W-1:0] w_b_el;
    logic [1:0]            w_shift;
    logic signed [B_W-1:0] w_cx;
    logic signed [B_W-1:0] w_sx;
    logic signed [B_W-1:0] w_cy;
    logic signed [B_W-1:0] w_sy;
    logic signed [A_W-1:0] w_fh;
    logic signed [A_W-1:0] w_fv;

    assign w_cx = B_W'(r_cx);
    assign w_sx = B_W'(r_sx);
    assign w_cy = B_W'(r_cy);
    assign w_sy = B_W'(r_sy);
    assign w_fh = $signed({1'b0, r_fov_h});
    assign w_fv = $signed({1'b0, r_fov_v});

    always_comb begin
        w_a_az  = '0;
        w_a_el  = '0;
        w_b_az  = '0;
        w_b_el  = '0;
        w_shift = SH_32;
        unique case (r_mode)
            spag_pkg::MODE_RASTER: begin
                w_a_az = w_fh;
                w_a_el = w_fv;
                w_b_az = $signed({2'b00, r_post_side.fx}) - spag_pkg::TURN_HALF;
                w_b_el = spag_pkg::TURN_HALF - $signed({2'b00, r_post_side.quo});
            end
            spag_pkg::MODE_SINUSOID, spag_pkg::MODE_LISSAJOUS: begin
                w_a_az  = w_fh;
                w_a_el  = w_fv;
                w_b_az  = w_sx;
                w_b_el  = w_sy;
                w_shift = SH_31;
            end
            spag_pkg::MODE_SPIRAL: begin
                w_a_az  = $signed({2'b00, r_post_side.radius});
                w_a_el  = $signed({2'b00, r_post_side.radius});
                w_b_az  = w_cx;
                w_b_el  = w_sx;
                w_shift = SH_30;
            end
            spag_pkg::MODE_ROSETTE: begin
                w_a_az = w_fh;
                w_a_el = w_fh;
                w_b_az = w_cx + w_cy;
                w_b_el = w_sx + w_sy;
            end
            spag_pkg::MODE_CIRCULAR: begin
                w_a_az = w_fh;
                w_a_el = w_fh;
                w_b_az = w_cx;
                w_b_el = w_sx;
            end
            default: ;
        endcase
    end

    logic                  r_mul_valid;
    logic signed [P_W-1:0] r_prod_az;
    logic signed [P_W-1:0] r_prod_el;
    logic [1:0]            r_mul_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (w_en) begin
            r_mul_valid <= r_post_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod_az   <= P_W'(w_a_az) * P_W'(w_b_az);
            r_prod_el   <= P_W'(w_a_el) * P_W'(w_b_el);
            r_mul_shift <= w_shift;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: floor scaling and saturation
    // ------------------------------------------------------------------
    logic signed [P_W-1:0]               w_sc_az;
    logic signed [P_W-1:0]               w_sc_el;
    logic signed [spag_pkg::ANGLE_W-1:0] w_sat_az;
    logic signed [spag_pkg::ANGLE_W-1:0] w_sat_el;
    logic signed [spag_pkg::ANGLE_W-1:0] r_out_az;
    logic signed [spag_pkg::ANGLE_W-1:0] r_out_el;

    always_comb begin
        case (r_mul_shift)
            SH_30: begin
                w_sc_az = r_prod_az >>> 30;
                w_sc_el = r_prod_el >>> 30;
            end
            SH_31: begin
                w_sc_az = r_prod_az >>> 31;
                w_sc_el = r_prod_el >>> 31;
            end
            default: begin
                w_sc_az = r_prod_az >>> 32;
                w_sc_el = r_prod_el >>> 32;
            end
        endcase
    end

    always_comb begin
        if (w_sc_az > SAT_MAX) begin
            w_sat_az = SAT_MAX[spag_pkg::ANGLE_W-1:0];
        end else if (w_sc_az < SAT_MIN) begin
            w_sat_az = SAT_MIN[spag_pkg::ANGLE_W-1:0];
        end else begin
            w_sat_az = w_sc_az[spag_pkg::ANGLE_W-1:0];
        end
        if (w_sc_el > SAT_MAX) begin
            w_sat_el = SAT_MAX[spag_pkg::ANGLE_W-1:0];
        end else if (w_sc_el < SAT_MIN) begin
            w_sat_el = SAT_MIN[spag_pkg::ANGLE_W-1:0];
        end else begin
            w_sat_el = w_sc_el[spag_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_az <= w_sat_az;
            r_out_el <= w_sat_el;
        end
    end

    assign o_angle.valid           = r_out_valid;
    assign o_angle.azimuth_angle   = r_out_az;
    assign o_angle.elevation_angle = r_out_el;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SPAG_ASSERT_NEXT(a_accept_enters_pipe, i_time.valid && i_time.ready, r_m1_valid)
    `SPAG_ASSERT_IMP(a_divisor_nonzero, r_m2_valid, w_divisor != '0)
    `SPAG_ASSERT_NEXT(a_stall_freezes_products, !w_en,
        $stable(r_mul_valid) && $stable(r_prod_az) && $stable(r_prod_el))
    `SPAG_ASSERT_NEXT(a_blank_mode_zero, w_en && (r_mode == spag_pkg::MODE_BLANK_LO ||
        r_mode == spag_pkg::MODE_BLANK_HI), r_prod_az == '0 && r_prod_el == '0)

endmodule

// ===== verif/tb_scan_pattern_angle_generator_top.sv =====
// ----------------------------------------------------------------------------
// tb_scan_pattern_angle_generator_top
// Drives time stamps under several register settings and compares every
// angle pair with a bit-true predictor of the scan patterns.
// ----------------------------------------------------------------------------
module tb_scan_pattern_angle_generator_top;

    localparam int LATENCY     = 94;
    localparam int DRAIN_WAIT  = 2 * LATENCY + 20;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic signed [spag_pkg::ANGLE_W-1:0] az;
        logic signed [spag_pkg::ANGLE_W-1:0] el;
    } t_angle_pair;

    logic i_clk;
    logic i_rst_n;

    spag_time_if  time_ch ();
    spag_angle_if angle_ch ();
    spag_cfg_if   cfg_ch ();

    scan_pattern_angle_generator_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_time  (time_ch.sink),
        .o_angle (angle_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Register shadow
    logic [spag_pkg::MODE_W-1:0]  shadow_mode;
    logic [spag_pkg::FOV_W-1:0]   shadow_fov_h;
    logic [spag_pkg::FOV_W-1:0]   shadow_fov_v;
    logic [spag_pkg::FREQ_W-1:0]  shadow_fast_freq;
    logic [spag_pkg::FREQ_W-1:0]  shadow_slow_freq;
    logic [spag_pkg::LINES_W-1:0] shadow_lines;

    t_angle_pair pending_angles[$];
    int          mismatch_count;
    int          angle_count;
    int          idle_cycles;
    bit          rx_stall_on;
    logic [7:0]  rx_pattern;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic void split_cycles(input logic [31:0] freq, input logic [47:0] t,
                                         output logic [63:0] whole,
                                         output logic [31:0] frac);
        logic [79:0] prod;
        prod  = freq * t;
        frac  = prod[47:16];
        whole = 64'(prod[79:48]);
    endfunction

    function automatic void cordic_turn(input logic [31:0] phase,
                                        output longint c, output longint s);
        longint z, x, y, dx, dy;
        bit     flip;
        z = longint'(phase);
        flip = 0;
        x = 652032874;
        y = 0;
        if (z >= 64'sd2147483648) z -= 64'sd4294967296;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            flip = 1;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            flip = 1;
        end
        for (int i = 0; i < spag_pkg::SINE_STEPS_DEFAULT; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(spag_pkg::ATAN_TURNS[i]);
            end else begin
                x += dx;
                y -= dy;
                z += longint'(spag_pkg::ATAN_TURNS[i]);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic logic signed [spag_pkg::ANGLE_W-1:0] clamp_angle(longint v);
        if (v > 67108863) v = 67108863;
        if (v < -67108864) v = -67108864;
        return v[spag_pkg::ANGLE_W-1:0];
    endfunction

    function automatic t_angle_pair predict_angles(logic [spag_pkg::TIME_W-1:0] t);
        logic [63:0] wx, wy, lines;
        logic [31:0] fx, fy;
        logic [95:0] num;
        longint fh, fv, cx, sx, cy, sy, az, el, m, p5, r, pv;
        t_angle_pair res;
        fh = longint'(shadow_fov_h);
        fv = longint'(shadow_fov_v);
        az = 0;
        el = 0;
        split_cycles(shadow_fast_freq, t, wx, fx);
        split_cycles(shadow_slow_freq, t, wy, fy);
        case (shadow_mode)
            spag_pkg::MODE_RASTER: begin
                lines = (shadow_lines == 0) ? 64'd1 : 64'(shadow_lines);
                num = {(wx % lines), fx};
                pv = longint'(num / lines);
                az = (fh * (longint'(fx) - 64'sd2147483648)) >>> 32;
                el = (fv * (64'sd2147483648 - pv)) >>> 32;
            end
            spag_pkg::MODE_SINUSOID, spag_pkg::MODE_LISSAJOUS: begin
                cordic_turn(fx, cx, sx);
                cordic_turn((shadow_mode == spag_pkg::MODE_LISSAJOUS) ?
                            fy + spag_pkg::TURN_EIGHTH : fy, cy, sy);
                az = (fh * sx) >>> 31;
                el = (fv * sy) >>> 31;
            end
            spag_pkg::MODE_SPIRAL: begin
                m = (fh < fv) ? fh : fv;
                num = {(wx % 64'd5), fx};
                p5 = longint'(num / 96'd5);
                r = (m * p5) >>> 33;
                cordic_turn(fx, cx, sx);
                az = (r * cx) >>> 30;
                el = (r * sx) >>> 30;
            end
            spag_pkg::MODE_ROSETTE: begin
                cordic_turn(fx, cx, sx);
                cordic_turn(fy, cy, sy);
                az = (fh * (cx + cy)) >>> 32;
                el = (fh * (sx + sy)) >>> 32;
            end
            spag_pkg::MODE_CIRCULAR: begin
                cordic_turn(fx, cx, sx);
                az = (fh * cx) >>> 32;
                el = (fh * sx) >>> 32;
            end
            default: ;
        endcase
        res.az = clamp_angle(az);
        res.el = clamp_angle(el);
        return res;
    endfunction

    // ---------------- drivers ----------------
    task automatic write_register(logic [spag_pkg::CFG_IDX_W-1:0] idx,
                                  logic [spag_pkg::CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            spag_pkg::CFG_PATTERN_MODE:   shadow_mode      = value[spag_pkg::MODE_W-1:0];
            spag_pkg::CFG_FOV_HORIZONTAL: shadow_fov_h     = value[spag_pkg::FOV_W-1:0];
            spag_pkg::CFG_FOV_VERTICAL:   shadow_fov_v     = value[spag_pkg::FOV_W-1:0];
            spag_pkg::CFG_FAST_FREQUENCY: shadow_fast_freq = value;
            spag_pkg::CFG_SLOW_FREQUENCY: shadow_slow_freq = value;
            spag_pkg::CFG_RASTER_LINES:   shadow_lines     = value[spag_pkg::LINES_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_pattern(logic [spag_pkg::MODE_W-1:0] mode,
                               logic [spag_pkg::FOV_W-1:0] fh,
                               logic [spag_pkg::FOV_W-1:0] fv, logic [31:0] ff,
                               logic [31:0] sf, logic [spag_pkg::LINES_W-1:0] lines);
        write_register(spag_pkg::CFG_PATTERN_MODE, 32'(mode));
        write_register(spag_pkg::CFG_FOV_HORIZONTAL, 32'(fh));
        write_register(spag_pkg::CFG_FOV_VERTICAL, 32'(fv));
        write_register(spag_pkg::CFG_FAST_FREQUENCY, ff);
        write_register(spag_pkg::CFG_SLOW_FREQUENCY, sf);
        write_register(spag_pkg::CFG_RASTER_LINES, 32'(lines));
    endtask

    // Send one time stamp; with hold_after set, the valid stays high across back-to-back transactions
    task automatic send_time_stamp(logic [spag_pkg::TIME_W-1:0] t, bit hold_after);
        time_ch.valid      <= 1'b1;
        time_ch.time_stamp <= t;
        do @(posedge i_clk); while (!time_ch.ready);
        pending_angles.push_back(predict_angles(t));
        if (!hold_after) begin
            time_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Bursts of random length with random gaps
    task automatic send_random_times(int count, bit full_range);
        int burst;
        logic [spag_pkg::TIME_W-1:0] t;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                repeat ($urandom_range(0, 4)) @(posedge i_clk);
                burst = $urandom_range(1, 20);
            end
            t = full_range ? spag_pkg::TIME_W'({$urandom, $urandom}) :
                spag_pkg::TIME_W'({$urandom_range(0, 255), $urandom});
            burst--;
            send_time_stamp(t, (burst != 0) && (n != count - 1));
        end
    endtask

    task automatic wait_drained();
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ---------------- checker ----------------
    always @(posedge i_clk) begin
        t_angle_pair exp_pair;
        if (!i_rst_n) begin
            angle_ch.ready <= 1'b0;
        end else begin
            if (angle_ch.valid && angle_ch.ready) begin
                angle_count++;
                if (pending_angles.size() == 0) begin
                    $error("unexpected angle pair az=%0d el=%0d",
                           angle_ch.azimuth_angle, angle_ch.elevation_angle);
                    mismatch_count++;
                end else begin
                    exp_pair = pending_angles.pop_front();
                    if (angle_ch.azimuth_angle !== exp_pair.az) begin
                        $error("azimuth_angle expected %0d actual %0d",
                               exp_pair.az, angle_ch.azimuth_angle);
                        mismatch_count++;
                    end
                    if (angle_ch.elevation_angle !== exp_pair.el) begin
                        $error("elevation_angle expected %0d actual %0d",
                               exp_pair.el, angle_ch.elevation_angle);
                        mismatch_count++;
                    end
                end
            end
            // Stall on a shifting pseudo-random pattern, switched on and off in stretches
            rx_pattern <= {rx_pattern[6:0], rx_pattern[7] ^ rx_pattern[5] ^ rx_pattern[4]
                           ^ rx_pattern[3]};
            if ($urandom_range(0, 99) == 0) rx_stall_on <= ~rx_stall_on;
            angle_ch.ready <= rx_stall_on ? rx_pattern[0] : 1'b1;
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((time_ch.valid && time_ch.ready) || (angle_ch.valid && angle_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("tb_scan_pattern_angle_generator_top failed");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_reset_defaults();
        send_time_stamp(48'h0000_8000_0000, 0);
        send_time_stamp('1, 0);
        wait_drained();
    endtask

    task automatic test_raster();
        set_pattern(spag_pkg::MODE_RASTER, 27'd67108864, 27'd33554432, 32'h0001_0000,
                    32'd0, 16'd0);
        send_time_stamp(48'd0, 1);
        send_time_stamp(48'h0000_4000_0000, 1);
        send_time_stamp('1, 0);
        wait_drained();
        set_pattern(spag_pkg::MODE_RASTER, 27'h7FF_FFFF, 27'h7FF_FFFF, 32'hFFFF_FFFF,
                    32'd0, 16'hFFFF);
        send_time_stamp(48'h8000_0000_0001, 1);
        send_time_stamp('1, 0);
        send_random_times(60, 1);
        wait_drained();
        set_pattern(spag_pkg::MODE_RASTER, 27'd20000000, 27'd9000000, 32'h0064_0000,
                    32'd0, 16'd7);
        send_random_times(60, 0);
        wait_drained();
    endtask

    task automatic test_trig_modes();
        for (int m = spag_pkg::MODE_SINUSOID; m <= spag_pkg::MODE_CIRCULAR; m++) begin
            set_pattern(spag_pkg::MODE_W'(m), 27'd67108864, 27'd67108864, 32'h0001_0000,
                        32'h0000_8000, 16'd1);
            send_time_stamp(48'h0000_2000_0000, 1);
            send_time_stamp(48'h0003_C000_0000, 0);
            wait_drained();
            set_pattern(spag_pkg::MODE_W'(m), $urandom_range(0, 67108864),
                        $urandom_range(0, 67108864), $urandom, $urandom, 16'($urandom));
            send_random_times(50, $urandom_range(0, 1));
            wait_drained();
        end
        // Spiral with vertical the smaller side, full-scale frequencies and horizontal field
        set_pattern(spag_pkg::MODE_SPIRAL, 27'h7FF_FFFF, 27'd1000, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 16'd3);
        send_random_times(30, 1);
        wait_drained();
    endtask

    task automatic test_blank_modes();
        set_pattern(spag_pkg::MODE_BLANK_LO, 27'd67108864, 27'd67108864, 32'd12345,
                    32'd678, 16'd2);
        send_random_times(10, 1);
        wait_drained();
        write_register(spag_pkg::CFG_PATTERN_MODE, 32'(spag_pkg::MODE_BLANK_HI));
        send_random_times(10, 1);
        wait_drained();
    endtask

    task automatic test_random_settings();
        for (int k = 0; k < 6; k++) begin
            set_pattern(spag_pkg::MODE_W'($urandom_range(0, 7)), $urandom_range(0, 67108864),
                        $urandom_range(0, 67108864), $urandom, $urandom,
                        16'($urandom_range(0, 300)));
            send_random_times(25, $urandom_range(0, 1));
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        time_ch.valid      = 1'b0;
        time_ch.time_stamp = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        angle_ch.ready     = 1'b0;
        rx_stall_on        = 1'b0;
        rx_pattern         = 8'hA5;
        mismatch_count     = 0;
        angle_count        = 0;
        idle_cycles        = 0;
        shadow_mode        = spag_pkg::MODE_RASTER;
        shadow_fov_h       = '0;
        shadow_fov_v       = '0;
        shadow_fast_freq   = '0;
        shadow_slow_freq   = '0;
        shadow_lines       = 16'd1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_raster();
        test_trig_modes();
        test_blank_modes();
        test_random_settings();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Covered all eight pattern modes with extreme and random registers;");
        $display("%0d angle pairs checked.", angle_count);
        if (mismatch_count == 0 && pending_angles.size() == 0) begin
            $display("tb_scan_pattern_angle_generator_top passed");
        end else begin
            $display("tb_scan_pattern_angle_generator_top failed");
        end
        $finish;
    end
endmodule
